// File: hdl/max_pool_2d_stream_defines.svh
// Assertion macros for the block's top module, max_pool_2d_stream.
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MP2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MP2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mp2d_pkg.sv
package mp2d_pkg;
    localparam int MAX_POOL_DEF     = 4;
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;
    localparam int OCOL_W     = 8;
    localparam int OCH_W      = 6;
    localparam int PREG_W     = 3;
    localparam int WREG_W     = 9;
    localparam int HREG_W     = 12;
    localparam int CREG_W     = 7;
    localparam int CMP_W      = 14;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;
endpackage

// File: hdl/max_pool_2d_stream.sv
// A beat without a complete window passes S_EVAL, then S_IDLE takes the next beat.
// A beat that completes a window stays in S_READ for one bank read per window column,
// in S_DRAIN while the maximum passes the chain of MAX_POOL row cells, and in S_OUT
// until the output register is free. The first beat after a configuration write also
// passes S_DIVS and S_DIV for the stride dividers. Reset is synchronous, active low;
// it clears position and control and sets default configuration, not the line store.
`include "max_pool_2d_stream_defines.svh"

module max_pool_2d_stream #(
    parameter int MAX_POOL     = mp2d_pkg::MAX_POOL_DEF,
    parameter int MAX_WIDTH    = mp2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mp2d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_value,
    input  logic                               i_image_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_pooled_value,
    output logic [mp2d_pkg::ROW_W-1:0]         o_out_row,
    output logic [mp2d_pkg::OCOL_W-1:0]        o_out_col,
    output logic [mp2d_pkg::OCH_W-1:0]         o_out_channel,
    output logic                               o_image_done
);
    import mp2d_pkg::*;

    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W     = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int BANK_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVS  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic signed [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [PREG_W-1:0] r_pool_w, r_pool_h, r_stride_w, r_stride_h;
    logic [WREG_W-1:0] r_img_w;
    logic [HREG_W-1:0] r_img_h;
    logic [CREG_W-1:0] r_chan_cnt;

    logic [2:0]        r_state;
    logic              r_dirty;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CH_W-1:0]   r_ch;
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0]  r_q_r;
    logic [PREG_W-1:0] r_m_r;
    logic [COL_W-1:0]  r_q_c;
    logic [PREG_W-1:0] r_m_c;

    logic [COL_W-1:0]    r_left;
    logic [CH_W-1:0]     r_wch;
    logic [STEP_W-1:0]   r_x;
    logic [STEP_W-1:0]   r_nbeat;
    logic [MAX_POOL-1:0] r_en;
    logic signed [SAMPLE_BITS-1:0] r_acc;
    logic [ROW_W-1:0]  r_orow;
    logic [COL_W-1:0]  r_ocol;
    logic [CH_W-1:0]   r_och;
    logic              r_last;

    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_opool;
    logic [ROW_W-1:0]              r_orow_o;
    logic [OCOL_W-1:0]             r_ocol_o;
    logic [OCH_W-1:0]              r_och_o;
    logic                          r_odone;

    logic [STEP_W-1:0] w_pw, w_ph;
    logic [PREG_W-1:0] w_sw, w_sh;
    logic [CMP_W-1:0]  w_w, w_h, w_c;
    logic              w_accept;
    logic              w_row_zero, w_col_zero, w_ch_zero;
    logic [ROW_W-1:0]  w_p_row;
    logic [COL_W-1:0]  w_p_col;
    logic [CH_W-1:0]   w_p_ch;
    logic [SLOT_W-1:0] w_p_slot;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [MAX_POOL-1:0] w_wr_en;
    logic              w_ok_r, w_ok_c, w_win;
    logic              w_ch_last, w_col_last, w_row_last;
    logic [ROW_W-1:0]  n_q_r;
    logic [PREG_W-1:0] n_m_r;
    logic [COL_W-1:0]  n_q_c;
    logic [PREG_W-1:0] n_m_c;
    logic [MAX_POOL-1:0] n_en;
    logic [ROW_W-1:0]  w_num_r;
    logic [COL_W:0]    w_num_c;
    logic              w_busy_r, w_busy_c;
    logic [ROW_W-1:0]  w_quot_r;
    logic [COL_W:0]    w_quot_c;
    logic [PREG_W-1:0] w_rem_r, w_rem_c;
    logic              w_out_free;
    logic              w_tail_valid;
    logic signed [SAMPLE_BITS-1:0] w_tail_max;

    logic                          w_rd   [MAX_POOL+1];
    logic [ADDR_W-1:0]             w_addr [MAX_POOL+1];
    logic signed [SAMPLE_BITS-1:0] w_max  [MAX_POOL+1];
    logic                          w_mv   [MAX_POOL+1];

    always_comb begin
        if (r_pool_w == '0) begin
            w_pw = STEP_W'(1);
        end else if (STEP_W'(r_pool_w) > STEP_W'(MAX_POOL)) begin
            w_pw = STEP_W'(MAX_POOL);
        end else begin
            w_pw = STEP_W'(r_pool_w);
        end
        if (r_pool_h == '0) begin
            w_ph = STEP_W'(1);
        end else if (STEP_W'(r_pool_h) > STEP_W'(MAX_POOL)) begin
            w_ph = STEP_W'(MAX_POOL);
        end else begin
            w_ph = STEP_W'(r_pool_h);
        end
        w_sw = (r_stride_w == '0) ? PREG_W'(1) : r_stride_w;
        w_sh = (r_stride_h == '0) ? PREG_W'(1) : r_stride_h;
        if (r_img_w == '0) begin
            w_w = CMP_W'(1);
        end else if (CMP_W'(r_img_w) > CMP_W'(MAX_WIDTH)) begin
            w_w = CMP_W'(MAX_WIDTH);
        end else begin
            w_w = CMP_W'(r_img_w);
        end
        w_h = (r_img_h == '0) ? CMP_W'(1) : CMP_W'(r_img_h);
        if (r_chan_cnt == '0) begin
            w_c = CMP_W'(1);
        end else if (CMP_W'(r_chan_cnt) > CMP_W'(MAX_CHANNELS)) begin
            w_c = CMP_W'(MAX_CHANNELS);
        end else begin
            w_c = CMP_W'(r_chan_cnt);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_row_zero = i_image_start || (CMP_W'(r_row) >= w_h);
    assign w_col_zero = i_image_start || (CMP_W'(r_col) >= w_w);
    assign w_ch_zero  = i_image_start || (CMP_W'(r_ch) >= w_c);
    assign w_p_row    = w_row_zero ? '0 : r_row;
    assign w_p_col    = w_col_zero ? '0 : r_col;
    assign w_p_ch     = w_ch_zero ? '0 : r_ch;
    assign w_p_slot   = w_row_zero ? '0 : r_slot;
    assign w_wr_addr  = ADDR_W'(ADDR_W'(w_p_col) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(w_p_ch);

    always_comb begin
        for (int k = 0; k < MAX_POOL; k++) begin
            w_wr_en[k] = w_accept && (w_p_slot == SLOT_W'(k));
        end
    end

    assign w_ok_r = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(w_ph);
    assign w_ok_c = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(w_pw);
    assign w_win  = w_ok_r && w_ok_c && (r_m_r == '0) && (r_m_c == '0);

    assign w_ch_last  = (CMP_W'(r_ch) + CMP_W'(1)) >= w_c;
    assign w_col_last = (CMP_W'(r_col) + CMP_W'(1)) >= w_w;
    assign w_row_last = (CMP_W'(r_row) + CMP_W'(1)) >= w_h;

    always_comb begin
        n_q_r = '0;
        n_m_r = '0;
        if (w_ok_r) begin
            if ({1'b0, r_m_r} + 1'b1 == {1'b0, w_sh}) begin
                n_q_r = r_q_r + 1'b1;
            end else begin
                n_q_r = r_q_r;
                n_m_r = r_m_r + 1'b1;
            end
        end
        n_q_c = '0;
        n_m_c = '0;
        if (w_ok_c) begin
            if ({1'b0, r_m_c} + 1'b1 == {1'b0, w_sw}) begin
                n_q_c = r_q_c + 1'b1;
            end else begin
                n_q_c = r_q_c;
                n_m_c = r_m_c + 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_POOL; k++) begin
            if (STEP_W'(r_slot) >= STEP_W'(k)) begin
                n_en[k] = (STEP_W'(r_slot) - STEP_W'(k)) < w_ph;
            end else begin
                n_en[k] = (STEP_W'(r_slot) + STEP_W'(MAX_POOL) - STEP_W'(k)) < w_ph;
            end
        end
    end

    assign w_num_r = w_ok_r ? ROW_W'(CMP_W'(r_row) + CMP_W'(1) - CMP_W'(w_ph)) : '0;
    assign w_num_c = w_ok_c ? (COL_W+1)'(CMP_W'(r_col) + CMP_W'(1) - CMP_W'(w_pw)) : '0;

    mp2d_div #(
        .NUM_W (ROW_W),
        .DEN_W (PREG_W)
    ) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVS),
        .i_num   (w_num_r),
        .i_den   (w_sh),
        .o_busy  (w_busy_r),
        .o_quot  (w_quot_r),
        .o_rem   (w_rem_r)
    );

    mp2d_div #(
        .NUM_W (COL_W + 1),
        .DEN_W (PREG_W)
    ) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVS),
        .i_num   (w_num_c),
        .i_den   (w_sw),
        .o_busy  (w_busy_c),
        .o_quot  (w_quot_c),
        .o_rem   (w_rem_c)
    );

    assign w_rd[0]   = (r_state == S_READ);
    assign w_addr[0] = ADDR_W'((ADDR_W'(r_left) + ADDR_W'(r_x)) * ADDR_W'(MAX_CHANNELS))
                       + ADDR_W'(r_wch);
    assign w_max[0]  = MIN_VAL;
    assign w_mv[0]   = w_rd[1];

    for (genvar k = 0; k < MAX_POOL; k++) begin : g_cell
        mp2d_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .DEPTH       (BANK_DEPTH),
            .ADDR_W      (ADDR_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en[k]),
            .i_wr_addr   (w_wr_addr),
            .i_wr_data   (i_sample_value),
            .i_en        (r_en[k]),
            .i_rd        (w_rd[k]),
            .i_addr      (w_addr[k]),
            .i_max       (w_max[k]),
            .i_max_valid (w_mv[k]),
            .o_rd        (w_rd[k+1]),
            .o_addr      (w_addr[k+1]),
            .o_max       (w_max[k+1]),
            .o_max_valid (w_mv[k+1])
        );
    end

    assign w_tail_valid = w_mv[MAX_POOL];
    assign w_tail_max   = w_max[MAX_POOL];
    assign w_out_free   = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_w   <= PREG_W'(2);
            r_pool_h   <= PREG_W'(2);
            r_stride_w <= PREG_W'(2);
            r_stride_h <= PREG_W'(2);
            r_img_w    <= WREG_W'(256);
            r_img_h    <= HREG_W'(256);
            r_chan_cnt <= CREG_W'(1);
            r_dirty    <= 1'b0;
            r_state    <= S_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_ch       <= '0;
            r_slot     <= '0;
            r_q_r      <= '0;
            r_m_r      <= '0;
            r_q_c      <= '0;
            r_m_c      <= '0;
            r_ovalid   <= 1'b0;
            r_x        <= '0;
            r_nbeat    <= '0;
            r_en       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dirty <= 1'b1;
                unique case (i_cfg_index)
                    REG_POOL_WIDTH:    r_pool_w   <= i_cfg_data[PREG_W-1:0];
                    REG_POOL_HEIGHT:   r_pool_h   <= i_cfg_data[PREG_W-1:0];
                    REG_STRIDE_WIDTH:  r_stride_w <= i_cfg_data[PREG_W-1:0];
                    REG_STRIDE_HEIGHT: r_stride_h <= i_cfg_data[PREG_W-1:0];
                    REG_IMAGE_WIDTH:   r_img_w    <= i_cfg_data[WREG_W-1:0];
                    REG_IMAGE_HEIGHT:  r_img_h    <= i_cfg_data[HREG_W-1:0];
                    REG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data[CREG_W-1:0];
                    default: ;
                endcase
            end

            if (o_out_valid && i_out_ready && !((r_state == S_OUT) && w_out_free)) begin
                r_ovalid <= 1'b0;
            end

            if (w_tail_valid) begin
                r_nbeat <= r_nbeat + 1'b1;
                if (w_tail_max > r_acc) begin
                    r_acc <= w_tail_max;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_row  <= w_p_row;
                        r_col  <= w_p_col;
                        r_ch   <= w_p_ch;
                        r_slot <= w_p_slot;
                        if (w_row_zero) begin
                            r_q_r <= '0;
                            r_m_r <= '0;
                        end
                        if (w_col_zero) begin
                            r_q_c <= '0;
                            r_m_c <= '0;
                        end
                        if (r_dirty && !i_cfg_valid) begin
                            r_dirty <= 1'b0;
                        end
                        r_state <= r_dirty ? S_DIVS : S_EVAL;
                    end
                end
                S_DIVS: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_busy_r && !w_busy_c) begin
                        r_q_r   <= w_quot_r;
                        r_m_r   <= w_rem_r;
                        r_q_c   <= COL_W'(w_quot_c);
                        r_m_c   <= w_rem_c;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_win) begin
                        r_left  <= COL_W'(CMP_W'(r_col) + CMP_W'(1) - CMP_W'(w_pw));
                        r_wch   <= r_ch;
                        r_x     <= '0;
                        r_nbeat <= '0;
                        r_acc   <= MIN_VAL;
                        r_en    <= n_en;
                        r_orow  <= r_q_r;
                        r_ocol  <= r_q_c;
                        r_och   <= r_ch;
                        r_last  <= ((CMP_W'(r_row) + CMP_W'(w_sh)) >= w_h)
                                && ((CMP_W'(r_col) + CMP_W'(w_sw)) >= w_w)
                                && w_ch_last;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    if (!w_ch_last) begin
                        r_ch <= r_ch + 1'b1;
                    end else begin
                        r_ch <= '0;
                        if (!w_col_last) begin
                            r_col <= r_col + 1'b1;
                            r_q_c <= n_q_c;
                            r_m_c <= n_m_c;
                        end else begin
                            r_col <= '0;
                            r_q_c <= '0;
                            r_m_c <= '0;
                            if (!w_row_last) begin
                                r_row <= r_row + 1'b1;
                                r_q_r <= n_q_r;
                                r_m_r <= n_m_r;
                                r_slot <= (r_slot == SLOT_W'(MAX_POOL - 1)) ? '0
                                                                            : r_slot + 1'b1;
                            end else begin
                                r_row  <= '0;
                                r_q_r  <= '0;
                                r_m_r  <= '0;
                                r_slot <= '0;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_x <= r_x + 1'b1;
                    if (r_x + 1'b1 == w_pw) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_tail_valid && (r_nbeat + 1'b1 == w_pw)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        if ((r_state == S_OUT) && w_out_free) begin
            r_opool  <= r_acc;
            r_orow_o <= r_orow;
            r_ocol_o <= OCOL_W'(r_ocol);
            r_och_o  <= OCH_W'(r_och);
            r_odone  <= r_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_pooled_value = r_opool;
    assign o_out_row      = r_orow_o;
    assign o_out_col      = r_ocol_o;
    assign o_out_channel  = r_och_o;
    assign o_image_done   = r_odone;

    `MP2D_ASSERT_NOW(a_one_bank_written, w_accept, $onehot(w_wr_en), "not exactly one bank written")
    `MP2D_ASSERT_NOW(a_window_has_bank, r_state == S_READ, r_en != '0, "window selects no row")
    `MP2D_ASSERT_NOW(a_div_only_resync, w_busy_r || w_busy_c, r_state == S_DIV, "divider busy")
    `MP2D_ASSERT_NOW(a_tail_in_window, w_tail_valid, r_state == S_READ || r_state == S_DRAIN, "stray beat")
    `MP2D_ASSERT_NEXT(a_read_goes_on, r_state == S_READ, r_state == S_READ || r_state == S_DRAIN, "read cut")
endmodule

// File: hdl/mp2d_ram.sv
module mp2d_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hdl/mp2d_div.sv
module mp2d_div #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_shift;
    logic             w_fit;

    assign w_shift = {r_rem, r_quot[NUM_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
            r_quot <= {r_quot[NUM_W-2:0], w_fit};
            r_rem  <= w_fit ? DEN_W'(w_shift - {1'b0, r_den}) : w_shift[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

// File: hdl/mp2d_cell.sv
module mp2d_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int DEPTH       = 256,
    parameter int ADDR_W      = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_data,
    input  logic                          i_en,
    input  logic                          i_rd,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_max,
    input  logic                          i_max_valid,
    output logic                          o_rd,
    output logic [ADDR_W-1:0]             o_addr,
    output logic signed [SAMPLE_BITS-1:0] o_max,
    output logic                          o_max_valid
);
    logic                          r_rd;
    logic [ADDR_W-1:0]             r_addr;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_mv;
    logic [SAMPLE_BITS-1:0]        w_data;
    logic signed [SAMPLE_BITS-1:0] w_sdata;
    logic signed [SAMPLE_BITS-1:0] n_max;

    mp2d_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd),
        .i_rd_addr (i_addr),
        .o_rd_data (w_data)
    );

    assign w_sdata = w_data;
    assign n_max   = (i_en && (w_sdata > i_max)) ? w_sdata : i_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_mv <= 1'b0;
        end else begin
            r_rd <= i_rd;
            r_mv <= i_max_valid;
        end
        r_addr <= i_addr;
        r_max  <= n_max;
    end

    assign o_rd        = r_rd;
    assign o_addr      = r_addr;
    assign o_max       = r_max;
    assign o_max_valid = r_mv;
endmodule
